// ===== rtl/pidt_pkg.sv =====
// ----------------------------------------------------------------------------
// pidt_pkg: shared definitions for the three-form PID controller
// Formats, register indexes, mode codes, sequencer states and the control
// structs that pass between the sequencer, the shared multiply-accumulate
// unit and the top level.
// ----------------------------------------------------------------------------
package pidt_pkg;

  // Data values are Q16.16, coefficients are Q8.24.
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 24;
  localparam int SUM_W      = DATA_W + 16;

  // The multiplier operand is split into a low unsigned word and a signed high part.
  localparam int OPND_W     = SUM_W;
  localparam int LO_W       = 32;
  localparam int MUL_A_W    = LO_W + 1;
  localparam int MUL_W      = MUL_A_W + COEF_W;
  localparam int RND_W      = MUL_W - COEF_FRAC;

  // Accumulator of the shared unit: holds a few terms plus the previous output.
  localparam int ACC_W      = 60;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLT_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLT_FB   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OUT = 3'd6;

  // Controller forms.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_POS  = 2'd0;
  localparam mode_t MODE_IIR  = 2'd1;
  localparam mode_t MODE_FILT = 2'd2;
  localparam mode_t MODE_HOLD = 2'd3;

  // Term sequencing: index of each product term within one sample.
  localparam int OP_IDX_W = 3;
  localparam logic [OP_IDX_W-1:0] OP_FIRST      = 3'd0;
  localparam logic [OP_IDX_W-1:0] OP_LAST_SHORT = 3'd2;
  localparam logic [OP_IDX_W-1:0] OP_LAST_FILT  = 3'd4;
  localparam logic [OP_IDX_W-1:0] OP_FILT_RAW   = 3'd0;
  localparam logic [OP_IDX_W-1:0] OP_FILT_LPF   = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_LO,
    ST_HI,
    ST_TERM,
    ST_ACC,
    ST_CLIP,
    ST_DONE
  } pidt_state_t;

  // Phase strobes for the shared multiply-accumulate unit.
  typedef struct packed {
    logic load_opnd;
    logic mul_lo;
    logic mul_hi;
    logic make_term;
    logic accum;
    logic load_acc;
  } mac_ctrl_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic                prep;
    logic                load;
    logic                clip;
    logic                done;
    logic [OP_IDX_W-1:0] op_idx;
  } seq_status_t;

endpackage

// ===== rtl/pidt_mac.sv =====
// ----------------------------------------------------------------------------
// pidt_mac: shared multiply-accumulate unit
// Forms round(operand * coef / 2^COEF_FRAC) with one 33x32 multiplier used
// twice (low word, then high part) and adds or subtracts it into a wide
// accumulator.
// ----------------------------------------------------------------------------
module pidt_mac import pidt_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [OPND_W-1:0] opnd_in,
  input  logic signed [COEF_W-1:0] coef_in,
  input  logic                     sub_in,
  input  logic signed [ACC_W-1:0]  load_val,
  output logic signed [ACC_W-1:0]  acc
);

  localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(1) <<< (COEF_FRAC - 1);

  logic signed [OPND_W-1:0]  opnd;
  logic signed [COEF_W-1:0]  coef;
  logic                      sub;
  logic signed [MUL_W-1:0]   prod;
  logic signed [RND_W-1:0]   rnd;
  logic signed [ACC_W-1:0]   term;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [MUL_W-1:0]   rnd_full;
  logic signed [ACC_W-1:0]   term_next;

  // Multiplier input: low word as unsigned, or the signed high part.
  always_comb begin
    if (ctrl.mul_hi) begin
      mul_a = MUL_A_W'($signed(opnd[OPND_W-1:LO_W]));
    end else begin
      mul_a = $signed({1'b0, opnd[LO_W-1:0]});
    end
  end

  assign mul_p = mul_a * coef;

  // Round the low partial product to nearest, ties upward.
  assign rnd_full = (prod + RND_HALF) >>> COEF_FRAC;

  // Recombine: the high partial product carries weight 2^(LO_W - COEF_FRAC).
  assign term_next = (ACC_W'(prod) <<< (LO_W - COEF_FRAC)) + ACC_W'(rnd);

  // Operand, partial products, term and accumulator registers.
  always_ff @(posedge clk) begin
    if (ctrl.load_opnd) begin
      opnd <= opnd_in;
      coef <= coef_in;
      sub  <= sub_in;
    end
    if (ctrl.mul_lo || ctrl.mul_hi) begin
      prod <= mul_p;
    end
    if (ctrl.mul_hi) begin
      rnd <= rnd_full[RND_W-1:0];
    end
    if (ctrl.make_term) begin
      term <= term_next;
    end
    if (ctrl.load_acc) begin
      acc <= load_val;
    end else if (ctrl.accum) begin
      acc <= sub ? (acc - term) : (acc + term);
    end
  end

endmodule

// ===== rtl/pidt_seq.sv =====
// ----------------------------------------------------------------------------
// pidt_seq: sample sequencer
// Steps each sample through its product terms on the shared unit, with
// clipping points between them in the filtered form, and waits for the
// output register to be free before finishing.
// ----------------------------------------------------------------------------
module pidt_seq import pidt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  mode_t       mode,
  input  logic        out_free,
  output mac_ctrl_t   ctrl,
  output seq_status_t status,
  output logic        busy
);

  pidt_state_t         state, state_next;
  logic [OP_IDX_W-1:0] op_idx, op_idx_next;
  logic [OP_IDX_W-1:0] op_last;
  logic                clip_point;

  // State and term index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_idx <= OP_FIRST;
    end else begin
      state  <= state_next;
      op_idx <= op_idx_next;
    end
  end

  assign op_last    = (mode == MODE_FILT) ? OP_LAST_FILT : OP_LAST_SHORT;
  assign clip_point = (mode == MODE_FILT) &&
                      ((op_idx == OP_FILT_RAW) || (op_idx == OP_FILT_LPF));

  // Next state and phase strobes.
  always_comb begin
    state_next  = state;
    op_idx_next = op_idx;
    ctrl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.load_acc = 1'b1;
        op_idx_next   = OP_FIRST;
        state_next    = (mode == MODE_HOLD) ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load_opnd = 1'b1;
        state_next     = ST_LO;
      end
      ST_LO: begin
        ctrl.mul_lo = 1'b1;
        state_next  = ST_HI;
      end
      ST_HI: begin
        ctrl.mul_hi = 1'b1;
        state_next  = ST_TERM;
      end
      ST_TERM: begin
        ctrl.make_term = 1'b1;
        state_next     = ST_ACC;
      end
      ST_ACC: begin
        ctrl.accum = 1'b1;
        if (clip_point) begin
          state_next = ST_CLIP;
        end else if (op_idx == op_last) begin
          state_next = ST_DONE;
        end else begin
          op_idx_next = op_idx + 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_CLIP: begin
        ctrl.load_acc = 1'b1;
        op_idx_next   = op_idx + 1'b1;
        state_next    = ST_LOAD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign status.prep   = (state == ST_PREP);
  assign status.load   = (state == ST_LOAD);
  assign status.clip   = (state == ST_CLIP);
  assign status.done   = (state == ST_DONE) && out_free;
  assign status.op_idx = op_idx;
  assign busy          = (state != ST_IDLE);

endmodule

// ===== rtl/pid_controller_three_form.sv =====
// ----------------------------------------------------------------------------
// pid_controller_three_form: fixed-point PID controller, three forms
// Each sample runs three product terms in the positional and velocity forms
// and five in the filtered form, none in the hold code; each term passes
// through the load, low, high, term and accumulate steps on the single shared
// 33x32 multiplier. A new sample is taken only after the last one is finished.
// A finished result waits in the output register while the next sample is taken.
// Reset clears the configuration, the history and the result valid flag; the
// output state starts at zero.
// ----------------------------------------------------------------------------
module pid_controller_three_form import pidt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [DATA_W-1:0]     setpoint,
  input  logic signed [DATA_W-1:0]     measurement,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [DATA_W-1:0]     drive,
  output logic                         saturated,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam logic signed [ACC_W-1:0] DATA_MAX =
    {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DATA_MIN =
    {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
  localparam logic signed [SUM_W:0] ESUM_MAX = {2'b00, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W:0] ESUM_MIN = {2'b11, {(SUM_W - 1){1'b0}}};

  function automatic logic data_ovf(input logic signed [ACC_W-1:0] x);
    return (x > DATA_MAX) || (x < DATA_MIN);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    if (x > DATA_MAX) begin
      y = DATA_MAX;
    end else if (x < DATA_MIN) begin
      y = DATA_MIN;
    end else begin
      y = x;
    end
    return y[DATA_W-1:0];
  endfunction

  // Configuration registers.
  mode_t                   mode;
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, filter_gain, filter_feedback;
  logic signed [DATA_W-1:0] init_out;

  // Controller history.
  logic signed [DATA_W-1:0] err_h0, err_h1;
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [DATA_W-1:0] acc_out;
  logic signed [DATA_W-1:0] raw_d_prev, filt_d_prev;

  // Working registers of the current sample.
  logic signed [DATA_W-1:0] err_cur;
  logic signed [SUM_W-1:0]  err_sum_new;
  logic signed [DATA_W-1:0] raw_d, filt_d;
  logic                     sat_flag;

  logic                     sample_xfer, result_xfer, out_free, mode_write;
  logic signed [DATA_W:0]   diff;
  logic signed [SUM_W:0]    err_sum_wide;
  logic signed [OPND_W-1:0] err_d1, err_d2, raw_d_sum;
  logic signed [OPND_W-1:0] opnd_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic                     sub_sel;
  logic signed [ACC_W-1:0]  load_val;
  logic signed [ACC_W-1:0]  mac_acc;
  logic signed [DATA_W-1:0] mac_sat;
  logic                     mac_ovf;
  mac_ctrl_t                mac_ctrl;
  seq_status_t              seq_st;
  logic                     busy;

  assign sample_xfer  = sample_valid && !sample_stall;
  assign result_xfer  = result_valid && !result_stall;
  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = busy;
  assign mode_write   = cfg_write && (cfg_index == REG_MODE);

  assign diff         = (DATA_W + 1)'(setpoint) - (DATA_W + 1)'(measurement);
  assign err_sum_wide = (SUM_W + 1)'(err_sum) + (SUM_W + 1)'(err_cur);
  assign err_d1       = OPND_W'(err_cur) - OPND_W'(err_h0);
  assign err_d2       = OPND_W'(err_cur) - (OPND_W'(err_h0) <<< 1) + OPND_W'(err_h1);
  assign raw_d_sum    = OPND_W'(raw_d) + OPND_W'(raw_d_prev);
  assign mac_sat      = sat_data(mac_acc);
  assign mac_ovf      = data_ovf(mac_acc);

  pidt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (sample_xfer),
    .mode     (mode),
    .out_free (out_free),
    .ctrl     (mac_ctrl),
    .status   (seq_st),
    .busy     (busy)
  );

  pidt_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .opnd_in  (opnd_sel),
    .coef_in  (coef_sel),
    .sub_in   (sub_sel),
    .load_val (load_val),
    .acc      (mac_acc)
  );

  // Operand and coefficient of each term, by form and term index.
  always_comb begin
    opnd_sel = OPND_W'(err_cur);
    coef_sel = coef_a;
    sub_sel  = 1'b0;
    case (mode)
      MODE_POS: begin
        case (seq_st.op_idx)
          3'd1: begin
            opnd_sel = err_sum_new;
            coef_sel = coef_b;
          end
          3'd2: begin
            opnd_sel = err_d1;
            coef_sel = coef_c;
          end
          default: begin
            opnd_sel = OPND_W'(err_cur);
            coef_sel = coef_a;
          end
        endcase
      end
      MODE_IIR: begin
        case (seq_st.op_idx)
          3'd1: begin
            opnd_sel = OPND_W'(err_h0);
            coef_sel = coef_b;
          end
          3'd2: begin
            opnd_sel = OPND_W'(err_h1);
            coef_sel = coef_c;
          end
          default: begin
            opnd_sel = OPND_W'(err_cur);
            coef_sel = coef_a;
          end
        endcase
      end
      default: begin
        case (seq_st.op_idx)
          3'd0: begin
            opnd_sel = err_d2;
            coef_sel = coef_c;
          end
          3'd1: begin
            opnd_sel = raw_d_sum;
            coef_sel = filter_gain;
          end
          3'd2: begin
            opnd_sel = OPND_W'(filt_d_prev);
            coef_sel = filter_feedback;
            sub_sel  = 1'b1;
          end
          3'd3: begin
            opnd_sel = OPND_W'(err_cur);
            coef_sel = coef_a;
          end
          default: begin
            opnd_sel = OPND_W'(err_h0);
            coef_sel = coef_b;
          end
        endcase
      end
    endcase
  end

  // Accumulator start values: previous output in the IIR form, else zero; after
  // the filtered derivative is known, previous output plus that derivative.
  always_comb begin
    load_val = '0;
    if (seq_st.prep) begin
      load_val = (mode == MODE_IIR) ? ACC_W'(acc_out) : '0;
    end else if (seq_st.clip && (seq_st.op_idx == OP_FILT_LPF)) begin
      load_val = ACC_W'(acc_out) + ACC_W'(mac_sat);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_POS;
      coef_a          <= '0;
      coef_b          <= '0;
      coef_c          <= '0;
      filter_gain     <= '0;
      filter_feedback <= '0;
      init_out        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:     mode            <= cfg_data[1:0];
        REG_COEF_A:   coef_a          <= cfg_data[COEF_W-1:0];
        REG_COEF_B:   coef_b          <= cfg_data[COEF_W-1:0];
        REG_COEF_C:   coef_c          <= cfg_data[COEF_W-1:0];
        REG_FLT_GAIN: filter_gain     <= cfg_data[COEF_W-1:0];
        REG_FLT_FB:   filter_feedback <= cfg_data[COEF_W-1:0];
        REG_INIT_OUT: init_out        <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller history: cleared by a mode write (output state to init_out), committed as a non-hold sample ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_h0      <= '0;
      err_h1      <= '0;
      err_sum     <= '0;
      acc_out     <= '0;
      raw_d_prev  <= '0;
      filt_d_prev <= '0;
    end else if (mode_write) begin
      err_h0      <= '0;
      err_h1      <= '0;
      err_sum     <= '0;
      acc_out     <= init_out;
      raw_d_prev  <= '0;
      filt_d_prev <= '0;
    end else if (seq_st.done && (mode != MODE_HOLD)) begin
      err_h1  <= err_h0;
      err_h0  <= err_cur;
      acc_out <= mac_sat;
      if (mode == MODE_POS) begin
        err_sum <= err_sum_new;
      end
      if (mode == MODE_FILT) begin
        raw_d_prev  <= raw_d;
        filt_d_prev <= filt_d;
      end
    end
  end

  // Working values of the sample in flight and its saturation flag.
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      err_cur  <= sat_data(ACC_W'(diff));
      sat_flag <= data_ovf(ACC_W'(diff));
    end else if (seq_st.load && (mode == MODE_POS) && (seq_st.op_idx == OP_FIRST)) begin
      // The error sum is only needed from the second term on.
      if (err_sum_wide > ESUM_MAX) begin
        err_sum_new <= ESUM_MAX[SUM_W-1:0];
        sat_flag    <= 1'b1;
      end else if (err_sum_wide < ESUM_MIN) begin
        err_sum_new <= ESUM_MIN[SUM_W-1:0];
        sat_flag    <= 1'b1;
      end else begin
        err_sum_new <= err_sum_wide[SUM_W-1:0];
      end
    end else if (seq_st.clip) begin
      sat_flag <= sat_flag | mac_ovf;
      if (seq_st.op_idx == OP_FILT_RAW) begin
        raw_d <= mac_sat;
      end else begin
        filt_d <= mac_sat;
      end
    end
  end

  // Output register: loaded when a sample ends, freed by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (seq_st.done) begin
      result_valid <= 1'b1;
    end else if (result_xfer) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_st.done) begin
      if (mode == MODE_HOLD) begin
        drive     <= acc_out;
        saturated <= 1'b0;
      end else begin
        drive     <= mac_sat;
        saturated <= sat_flag | mac_ovf;
      end
    end
  end

endmodule

// ===== rtl/pidt_checker.sv =====
// ----------------------------------------------------------------------------
// pidt_checker: port-level checks for the PID controller
// Watches the sample and result channels of the top level over time and is
// attached to it by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module pidt_checker import pidt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     sample_valid,
  input logic                     sample_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic signed [DATA_W-1:0] drive,
  input logic                     saturated
);

  // A sample transfer always starts work, so the next sample must wait.
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while another is in progress");

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive) && $stable(saturated))
    else $error("stalled result changed");

  // A new result only appears at the end of a sample's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without work in progress");

  // Work ends only by presenting its result.
  a_done_shows_result: assert property (@(posedge clk) disable iff (rst)
    $fell(sample_stall) |-> result_valid)
    else $error("work ended without a result");

endmodule

bind pid_controller_three_form pidt_checker u_pidt_checker (.*);
